// ----- src/ryuv_pkg.sv -----
// shared constants for the rgb888 to planar yuv 4:2:0 converter
// no dependencies; used by rgb888_to_yuv420_planar and the testbench
package ryuv_pkg;

  // fixed-point fraction bits of the color coefficients
  localparam int unsigned FRAC_BITS = 12;

  // luma coefficients
  localparam logic [11:0] K_Y_R = 12'd1224;
  localparam logic [11:0] K_Y_G = 12'd2404;
  localparam logic [11:0] K_Y_B = 12'd469;

  // chroma coefficients
  localparam logic [11:0] K_U_R = 12'd692;
  localparam logic [11:0] K_U_G = 12'd1356;
  localparam logic [11:0] K_V_G = 12'd1731;
  localparam logic [11:0] K_V_B = 12'd334;

  // chroma offset
  localparam logic [7:0] CHROMA_BIAS = 8'd128;

  // default frame limits
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  // register reset values
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  // register map (index = byte address / 4)
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // output field widths
  localparam int unsigned OFS_W = 23;
  localparam int unsigned PIX_W = 22;

endpackage

// ----- src/rgb888_to_yuv420_planar.sv -----
// rgb888 pixel stream to planar yuv 4:2:0 sample stream with buffer offsets
// depends on ryuv_pkg
//
// usage:
//   s_axis: one pixel per beat, tdata = {red, green, blue}, blue in bits 7:0.
//   m_axis: one result beat per pixel: luma value and its offset; at odd
//     column and odd row (tuser high) also u, v and their offsets; tlast
//     marks the last pixel of the frame. every beat carries the total
//     length of the planar buffer.
//   apb: frame_width at address 0, frame_height at address 4 (12 bits each).
//     a zero acts as one, a value above the maximum acts as the maximum.
//     the frame area is multiplied out on the write itself.
// timing:
//   a result beat follows in the cycle after its pixel is taken. one pixel
//   is taken every cycle unless the receiver stalls a full result register;
//   multiplies and offset adds sit between input port and single result register.
//   when the receiver stalls, the result register holds and s_axis_tready
//   drops in the same cycle, so no beat is lost under backpressure.
// reset:
//   counters return to the top-left pixel, registers to 640 by 480, and the
//   result register empties.
module rgb888_to_yuv420_planar #(
  parameter int unsigned MAX_WIDTH  = ryuv_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ryuv_pkg::MAX_HEIGHT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // pixel input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] byte_first, [15:8] byte_middle, [23:16] byte_last
  input  logic [23:0]  s_axis_tdata,
  // result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] luma_value, [29:8] luma_offset, [37:30] u_value, [45:38] v_value,
  // [68:46] u_offset, [91:69] v_offset, [114:92] output_length, rest zero
  output logic [119:0] m_axis_tdata,
  // [0] chroma_valid
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // effective dimension: zero acts as one, clamp at the maximum
  function automatic int unsigned eff_dim(input logic [11:0] v, input int unsigned maxv);
    int unsigned vi;
    vi = 32'(v);
    if (vi == 0) begin
      return 1;
    end
    if (vi > maxv) begin
      return maxv;
    end
    return vi;
  endfunction

  localparam int unsigned EWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EWH = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned AW  = EWW + EWH;
  localparam int unsigned XW  = (AW > ryuv_pkg::OFS_W) ? AW + 1 : ryuv_pkg::OFS_W + 1;
  localparam int unsigned PW  = 8 + ryuv_pkg::FRAC_BITS;
  localparam int unsigned FB  = ryuv_pkg::FRAC_BITS;
  localparam int unsigned OW  = ryuv_pkg::OFS_W;
  localparam int unsigned PIX_W = ryuv_pkg::PIX_W;
  localparam int unsigned AREA_RST =
    eff_dim(ryuv_pkg::WIDTH_RST, MAX_WIDTH) * eff_dim(ryuv_pkg::HEIGHT_RST, MAX_HEIGHT);

  // configuration registers and the frame area
  logic [11:0]   width_q, height_q;
  logic [11:0]   width_d, height_d;
  logic [AW-1:0] area_q, area_d;
  logic          cfg_wr;
  logic          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[2];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      case (cfg_idx)
        ryuv_pkg::REG_FRAME_WIDTH:  width_d  = pwdata[11:0];
        ryuv_pkg::REG_FRAME_HEIGHT: height_d = pwdata[11:0];
        default: ;
      endcase
    end
    area_d = AW'(EWW'(eff_dim(width_d, MAX_WIDTH))) *
             AW'(EWH'(eff_dim(height_d, MAX_HEIGHT)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ryuv_pkg::WIDTH_RST;
      height_q <= ryuv_pkg::HEIGHT_RST;
      area_q   <= AW'(AREA_RST);
    end else if (cfg_wr) begin
      width_q  <= width_d;
      height_q <= height_d;
      area_q   <= area_d;
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      ryuv_pkg::REG_FRAME_WIDTH:  prdata = {20'd0, width_q};
      ryuv_pkg::REG_FRAME_HEIGHT: prdata = {20'd0, height_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // handshake: the result register frees up when it is taken
  logic out_valid_q;
  logic in_fire;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // raster position
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [PIX_W-1:0] pix_q;
  logic [OW-1:0]    chr_q;
  logic [EWW-1:0]   eff_w;
  logic [EWH-1:0]   eff_h;
  logic             last_col, last_row, flast, cv;

  assign eff_w    = EWW'(eff_dim(width_q, MAX_WIDTH));
  assign eff_h    = EWH'(eff_dim(height_q, MAX_HEIGHT));
  assign last_col = (EWW'(col_q) + EWW'(1)) >= eff_w;
  assign last_row = (EWH'(row_q) + EWH'(1)) >= eff_h;
  assign flast    = last_col && last_row;
  assign cv       = col_q[0] && row_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pix_q <= '0;
      chr_q <= '0;
    end else if (in_fire) begin
      if (flast) begin
        col_q <= '0;
        row_q <= '0;
        pix_q <= '0;
        chr_q <= '0;
      end else begin
        pix_q <= pix_q + PIX_W'(1);
        if (cv) begin
          chr_q <= chr_q + OW'(1);
        end
        if (last_col) begin
          col_q <= '0;
          row_q <= row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  // color conversion, each term floored on its own
  logic [7:0]    px_b, px_g, px_r;
  logic [PW-1:0] p_yr, p_yg, p_yb, p_ur, p_ug, p_vg, p_vb;
  logic [7:0]    luma, u_val, v_val;

  assign px_b = s_axis_tdata[7:0];
  assign px_g = s_axis_tdata[15:8];
  assign px_r = s_axis_tdata[23:16];

  assign p_yr = PW'(px_r) * PW'(ryuv_pkg::K_Y_R);
  assign p_yg = PW'(px_g) * PW'(ryuv_pkg::K_Y_G);
  assign p_yb = PW'(px_b) * PW'(ryuv_pkg::K_Y_B);
  assign p_ur = PW'(px_r) * PW'(ryuv_pkg::K_U_R);
  assign p_ug = PW'(px_g) * PW'(ryuv_pkg::K_U_G);
  assign p_vg = PW'(px_g) * PW'(ryuv_pkg::K_V_G);
  assign p_vb = PW'(px_b) * PW'(ryuv_pkg::K_V_B);

  // 8-bit wraparound matches the byte mask of the sums
  assign luma  = p_yr[PW-1:FB] + p_yg[PW-1:FB] + p_yb[PW-1:FB];
  assign u_val = {1'b0, px_b[7:1]} + ryuv_pkg::CHROMA_BIAS - p_ur[PW-1:FB] - p_ug[PW-1:FB];
  assign v_val = {1'b0, px_r[7:1]} + ryuv_pkg::CHROMA_BIAS - p_vg[PW-1:FB] - p_vb[PW-1:FB];

  // planar buffer offsets
  logic [XW-1:0] area_x, u_sum, v_sum, len_sum;

  assign area_x  = XW'(area_q);
  assign u_sum   = area_x + XW'(chr_q);
  assign v_sum   = area_x + (area_x >> 2) + XW'(chr_q);
  assign len_sum = area_x + (area_x >> 1);

  // result register
  logic [7:0]       luma_q, u_q, v_q;
  logic [PIX_W-1:0] luma_ofs_q;
  logic [OW-1:0]    u_ofs_q, v_ofs_q, len_q;
  logic             cv_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      luma_q     <= luma;
      luma_ofs_q <= pix_q;
      cv_q       <= cv;
      u_q        <= cv ? u_val : 8'd0;
      v_q        <= cv ? v_val : 8'd0;
      u_ofs_q    <= cv ? u_sum[OW-1:0] : '0;
      v_ofs_q    <= cv ? v_sum[OW-1:0] : '0;
      last_q     <= flast;
      len_q      <= len_sum[OW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, len_q, v_ofs_q, u_ofs_q, v_q, u_q, luma_ofs_q, luma_q};
  assign m_axis_tuser  = cv_q;
  assign m_axis_tlast  = last_q;

`ifndef SYNTHESIS
  // a frame end sends the raster back to the first pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && flast |=> col_q == '0 && row_q == '0 && pix_q == '0 && chr_q == '0)
    else $error("raster position not cleared after frame end");

  // every other pixel advances the pixel index by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !flast |=> pix_q == $past(pix_q) + PIX_W'(1))
    else $error("pixel index did not advance");

  // the chroma index counts chroma samples only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !flast && !cv |=> chr_q == $past(chr_q))
    else $error("chroma index moved on a luma-only pixel");

  // a result without chroma carries zero chroma fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !cv_q |-> u_q == 8'd0 && v_q == 8'd0 && u_ofs_q == '0 && v_ofs_q == '0)
    else $error("chroma fields set on a luma-only beat");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for rgb888_to_yuv420_planar: pixel beats in, yuv result beats out
// predicts each result from its own copy of the frame counters and registers
// depends on ryuv_pkg and the rgb888_to_yuv420_planar rtl
module testbench;

  // cycles without any beat before the run is declared hung
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RANDOM_PIXELS = 1650;
  localparam int unsigned HOLD_CYCLES   = 300;

  // color swatches; chroma is sampled at list positions 2, 6, 10 and 14
  localparam logic [23:0] SWATCHES [16] = '{
    24'h000000, 24'hFFFFFF, 24'h0000FF, 24'hAA55AA,
    24'h55AA55, 24'h00FF00, 24'hFFFF00, 24'hFF00FF,
    24'h808080, 24'h7F7F7F, 24'hFF0000, 24'h0F0F0F,
    24'hF0F0F0, 24'h123456, 24'h00FFFF, 24'hFEDCBA
  };

  typedef struct packed {
    logic [7:0]  luma;
    logic [21:0] luma_ofs;
    logic        chroma_ok;
    logic [7:0]  u_val;
    logic [7:0]  v_val;
    logic [22:0] u_ofs;
    logic [22:0] v_ofs;
    logic        frame_end;
    logic [22:0] buf_len;
  } yuv_beat_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // predictor copy of registers and frame position
  logic [11:0] frame_w_reg = ryuv_pkg::WIDTH_RST;
  logic [11:0] frame_h_reg = ryuv_pkg::HEIGHT_RST;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned pix_pos = 0;
  int unsigned chroma_pos = 0;

  yuv_beat_t expected_beats[$];

  int unsigned pixels_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned chroma_beats = 0;
  int unsigned frame_ends = 0;
  int unsigned frame_settings = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;

  rgb888_to_yuv420_planar dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_error(input string what);
    if (mismatch_count < 10) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  function automatic string beat_text(input yuv_beat_t x);
    return $sformatf("Y=%02h@%0h c=%0b U=%02h@%0h V=%02h@%0h last=%0b len=%0h",
                     x.luma, x.luma_ofs, x.chroma_ok, x.u_val, x.u_ofs,
                     x.v_val, x.v_ofs, x.frame_end, x.buf_len);
  endfunction

  // q12 constant multiply, floored
  function automatic int unsigned q12(input int unsigned v, input logic [11:0] k);
    return (v * 32'(k)) >> ryuv_pkg::FRAC_BITS;
  endfunction

  // zero acts as one, oversize clamps to the maximum
  function automatic int unsigned eff_dim(input logic [11:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  // expected result of one pixel; advances the frame position
  function automatic yuv_beat_t predict_pixel(input logic [23:0] px);
    int unsigned b, g, r, w, h, u_tmp, v_tmp;
    longint unsigned area;
    logic col_end, row_end;
    yuv_beat_t e;
    b = 32'(px[7:0]);
    g = 32'(px[15:8]);
    r = 32'(px[23:16]);
    w = eff_dim(frame_w_reg, ryuv_pkg::MAX_WIDTH_DEF);
    h = eff_dim(frame_h_reg, ryuv_pkg::MAX_HEIGHT_DEF);
    area = 64'(w);
    area = area * 64'(h);
    e = '0;
    e.luma = 8'(q12(r, ryuv_pkg::K_Y_R) + q12(g, ryuv_pkg::K_Y_G) + q12(b, ryuv_pkg::K_Y_B));
    e.luma_ofs = pix_pos[21:0];
    e.chroma_ok = col_pos[0] & row_pos[0];
    if (e.chroma_ok) begin
      u_tmp = (b >> 1) + 32'(ryuv_pkg::CHROMA_BIAS) - q12(r, ryuv_pkg::K_U_R)
              - q12(g, ryuv_pkg::K_U_G);
      v_tmp = (r >> 1) + 32'(ryuv_pkg::CHROMA_BIAS) - q12(g, ryuv_pkg::K_V_G)
              - q12(b, ryuv_pkg::K_V_B);
      e.u_val = u_tmp[7:0];
      e.v_val = v_tmp[7:0];
      e.u_ofs = 23'(area + chroma_pos);
      e.v_ofs = 23'((5 * area) / 4 + chroma_pos);
      chroma_pos++;
    end
    col_end = (col_pos + 1) >= w;
    row_end = (row_pos + 1) >= h;
    e.frame_end = col_end & row_end;
    e.buf_len = 23'(area + area / 2);
    // counters compare with >=, so a shrunk frame wraps right away
    if (e.frame_end) begin
      col_pos = 0;
      row_pos = 0;
      pix_pos = 0;
      chroma_pos = 0;
    end else begin
      pix_pos++;
      if (col_end) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
    end
    return e;
  endfunction

  function automatic logic [23:0] random_pixel();
    logic [23:0] px;
    px = 24'($urandom);
    // some pixels get saturated channels
    if ($urandom_range(4) == 0) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(2))
          0: px[8*i +: 8] = 8'h00;
          1: px[8*i +: 8] = 8'hFF;
          default: ;
        endcase
      end
    end
    return px;
  endfunction

  function automatic logic [11:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return 12'd0;
    if (r < 6) return 12'($urandom_range(2049, 4095));
    if (r < 9) return 12'd2048;
    if (r < 14) return 12'd1;
    if (r < 75) return 12'($urandom_range(2, 8));
    return 12'($urandom_range(9, 64));
  endfunction

  // one pixel beat; called and returns at a falling edge
  task automatic send_pixel(input logic [23:0] px);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_beats.push_back(predict_pixel(px));
    pixels_sent++;
    @(negedge clk_i);
    // an idle gap follows about one beat in twelve
    if (src_idle_en && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // stop sending and let every pending result drain
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [11:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {20'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (reg_idx == ryuv_pkg::REG_FRAME_WIDTH) frame_w_reg = value;
    else frame_h_reg = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_read(input logic reg_idx, input logic [11:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[11:0] !== want)
      flag_error($sformatf("register %0d read %0h, expected %0h", reg_idx, prdata[11:0], want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_frame(input logic [11:0] w, input logic [11:0] h);
    wait_for_results();
    apb_write(ryuv_pkg::REG_FRAME_WIDTH, w);
    apb_write(ryuv_pkg::REG_FRAME_HEIGHT, h);
    frame_settings++;
  endtask

  // register defaults and a few pixels at the default 640x480 frame
  task automatic test_reset_state();
    apb_read(ryuv_pkg::REG_FRAME_WIDTH, ryuv_pkg::WIDTH_RST);
    apb_read(ryuv_pkg::REG_FRAME_HEIGHT, ryuv_pkg::HEIGHT_RST);
    repeat (2) send_pixel(random_pixel());
  endtask

  // black, white, primaries and the u/v extremes on chroma pixels of a 2x2 frame
  task automatic test_color_extremes();
    set_frame(12'd2, 12'd2);
    apb_read(ryuv_pkg::REG_FRAME_WIDTH, 12'd2);
    apb_read(ryuv_pkg::REG_FRAME_HEIGHT, 12'd2);
    foreach (SWATCHES[i]) send_pixel(SWATCHES[i]);
  endtask

  // zero size acts as one, oversize clamps, then a shrink in the middle of a line
  task automatic test_dimension_limits();
    set_frame(12'd0, 12'd0);
    repeat (2) send_pixel(random_pixel());
    set_frame(12'hFFF, 12'hFFF);
    apb_read(ryuv_pkg::REG_FRAME_WIDTH, 12'hFFF);
    apb_read(ryuv_pkg::REG_FRAME_HEIGHT, 12'hFFF);
    repeat (3) send_pixel(random_pixel());
    set_frame(12'd2, 12'd1);
    repeat (2) send_pixel(random_pixel());
  endtask

  // receiver holds off a long time while pixels keep coming
  task automatic test_output_backpressure();
    set_frame(12'd6, 12'd4);
    src_idle_en = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (40) send_pixel(random_pixel());
    wait_for_results();
    src_idle_en = 1'b1;
  endtask

  // random frame sizes, pauses and resizes between bursts of random pixels
  task automatic test_random_frames();
    int unsigned sent_here;
    int unsigned n;
    // one long stretch without any idling
    set_frame(12'd8, 12'd6);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (200) send_pixel(random_pixel());
    sent_here = 200;
    while (sent_here < RANDOM_PIXELS) begin
      if ($urandom_range(3) != 0) set_frame(pick_dim(), pick_dim());
      else wait_for_results();
      src_idle_en = ($urandom_range(9) != 0);
      sink_idle_en = ($urandom_range(9) != 0);
      n = $urandom_range(10, 100);
      repeat (n) send_pixel(random_pixel());
      sent_here += n;
    end
    wait_for_results();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // result side ready, with random stalls and requested hold-offs
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= !(sink_idle_en && ($urandom_range(99) < 17));
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : check_results
    yuv_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.luma      = m_axis_tdata[7:0];
      got.luma_ofs  = m_axis_tdata[29:8];
      got.u_val     = m_axis_tdata[37:30];
      got.v_val     = m_axis_tdata[45:38];
      got.u_ofs     = m_axis_tdata[68:46];
      got.v_ofs     = m_axis_tdata[91:69];
      got.buf_len   = m_axis_tdata[114:92];
      got.chroma_ok = m_axis_tuser;
      got.frame_end = m_axis_tlast;
      if (got.chroma_ok) chroma_beats++;
      if (got.frame_end) frame_ends++;
      if (expected_beats.size() == 0) begin
        flag_error($sformatf("beat %0d arrived with nothing expected: %s",
                             beats_checked, beat_text(got)));
      end else begin
        want = expected_beats.pop_front();
        if (got !== want)
          flag_error($sformatf("beat %0d\n  expected %s\n  actual   %s",
                               beats_checked, beat_text(want), beat_text(got)));
      end
      beats_checked++;
    end
  end

  // hang detection
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results pending",
               quiet_cycles, expected_beats.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_color_extremes();
    test_dimension_limits();
    test_output_backpressure();
    test_random_frames();

    wait_for_results();
    repeat (5) @(posedge clk_i);
    if (expected_beats.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_beats.size()));

    $display("covered %0d pixels over %0d frame sizes: %0d result beats, %0d with chroma,",
             pixels_sent, frame_settings, beats_checked, chroma_beats);
    $display("%0d frame ends, %0d mismatches", frame_ends, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
